>>> rtl/bsfc_pkg.sv
// Shared types, register indexes and the phase table of the stepper sequencer.
`default_nettype none
package bsfc_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CHOP = 2'd1,
        MODE_GAP  = 2'd2
    } run_mode_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ON_TICKS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_TICKS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHOP_CYCLES   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_RUN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TICKS     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE       = 3'd5;

    localparam logic [7:0]  ON_TICKS_RESET      = 8'd35;
    localparam logic [7:0]  OFF_TICKS_RESET     = 8'd15;
    localparam logic [7:0]  CHOP_CYCLES_RESET   = 8'd100;
    localparam logic [7:0]  STEPS_PER_RUN_RESET = 8'd53;
    localparam logic [15:0] GAP_TICKS_RESET     = 16'd10000;

    typedef struct packed {
        logic [7:0]  on_ticks;
        logic [7:0]  off_ticks;
        logic [7:0]  chop_cycles;
        logic [7:0]  steps_per_run;
        logic [15:0] gap_ticks;
        logic        reverse;
    } cfg_t;

    typedef struct packed {
        logic pin_a1;
        logic pin_a2;
        logic pin_b1;
        logic pin_b2;
        logic led_on;
        logic busy_res;
    } res_t;

    // Bridge levels {a1, a2, b1, b2} for A+B+, A-B+, A-B-, A+B-.
    function automatic logic [3:0] phase_pattern(input logic [1:0] order);
        logic [3:0] pat;
        unique case (order)
            2'd0:    pat = 4'b1010;
            2'd1:    pat = 4'b0110;
            2'd2:    pat = 4'b0101;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage
`default_nettype wire

>>> rtl/bsfc_if.sv
// Request channels of the stepper sequencer: tick input and pin result.
`default_nettype none
interface bsfc_in_if;
    logic valid;
    logic ready;
    logic button_pressed;

    modport source (output valid, output button_pressed, input ready);
    modport sink (input valid, input button_pressed, output ready);
endinterface

interface bsfc_out_if;
    logic valid;
    logic ready;
    logic pin_a1;
    logic pin_a2;
    logic pin_b1;
    logic pin_b2;
    logic led_on;
    logic busy_res;

    modport source (output valid, output pin_a1, output pin_a2, output pin_b1,
                    output pin_b2, output led_on, output busy_res, input ready);
    modport sink (input valid, input pin_a1, input pin_a2, input pin_b1,
                  input pin_b2, input led_on, input busy_res, output ready);
endinterface
`default_nettype wire

>>> rtl/bipolar_stepper_fullstep_chopper.sv
// Bipolar stepper full-step sequencer with chopped phase drive.
//
// Channel tick (sink) carries one request per time tick with the button
// level; channel result (source) returns one request per tick with the four
// bridge pin levels, the ready LED level and the run flag. The result of a
// tick is registered: it appears in the cycle after the tick is accepted, and a
// new tick is taken every cycle while the result is drained, so the block
// sustains one tick per cycle. The single result register sets that figure:
// a tick is accepted when the register is empty or is being taken.
// When the receiver stalls, the result holds and tick.ready drops until the
// result is taken; sequencer state advances only on accepted ticks.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); writes
// to indexes past the register list are ignored. Writes take effect on the
// next tick.
// Reset loads the default timing registers, puts the sequencer idle with
// the LED lit and empties the result register.
`default_nettype none
module bipolar_stepper_fullstep_chopper
    import bsfc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    bsfc_in_if.sink                     tick,
    bsfc_out_if.source                  result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;
    res_t res_reg;
    res_t res_next;
    logic res_valid_reg;
    logic res_valid_next;
    logic advance;

    assign tick.ready     = !res_valid_reg || result.ready;
    assign advance        = tick.valid && tick.ready;
    assign res_valid_next = advance || (res_valid_reg && !result.ready);

    bsfc_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .button  (tick.button_pressed),
        .cfg     (cfg_reg),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_ticks      <= ON_TICKS_RESET;
            cfg_reg.off_ticks     <= OFF_TICKS_RESET;
            cfg_reg.chop_cycles   <= CHOP_CYCLES_RESET;
            cfg_reg.steps_per_run <= STEPS_PER_RUN_RESET;
            cfg_reg.gap_ticks     <= GAP_TICKS_RESET;
            cfg_reg.reverse       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ON_TICKS:      cfg_reg.on_ticks      <= cfg_data[7:0];
                REG_OFF_TICKS:     cfg_reg.off_ticks     <= cfg_data[7:0];
                REG_CHOP_CYCLES:   cfg_reg.chop_cycles   <= cfg_data[7:0];
                REG_STEPS_PER_RUN: cfg_reg.steps_per_run <= cfg_data[7:0];
                REG_GAP_TICKS:     cfg_reg.gap_ticks     <= cfg_data;
                REG_REVERSE:       cfg_reg.reverse       <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload register: load on every accepted tick, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid    = res_valid_reg;
    assign result.pin_a1   = res_reg.pin_a1;
    assign result.pin_a2   = res_reg.pin_a2;
    assign result.pin_b1   = res_reg.pin_b1;
    assign result.pin_b2   = res_reg.pin_b2;
    assign result.led_on   = res_reg.led_on;
    assign result.busy_res = res_reg.busy_res;

    // Every accepted tick leaves a result waiting on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("accepted tick produced no result");

    // Bridge pins are only driven during a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.busy_res) |->
        !(res_reg.pin_a1 || res_reg.pin_a2 || res_reg.pin_b1 || res_reg.pin_b2))
        else $error("pins driven outside a run");

    // The LED is dark on every tick of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.busy_res) |-> !res_reg.led_on)
        else $error("LED lit during a run");

    // Never drive both ends of one coil.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.pin_a1 && res_reg.pin_a2)
                          && !(res_reg.pin_b1 && res_reg.pin_b2))
        else $error("coil shorted");

endmodule
`default_nettype wire

>>> rtl/bsfc_seq.sv
// Run sequencer: mode, phase, chop and step counters, one tick per advance.
`default_nettype none
module bsfc_seq
    import bsfc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire logic button,
    input  wire cfg_t cfg,
    output res_t      res
);

    run_mode_t   mode_reg, mode_next;
    logic [1:0]  phase_reg, phase_next;
    logic        half_reg, half_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  chop_reg, chop_next;
    logic [7:0]  step_reg, step_next;
    logic        led_reg, led_next;

    logic [15:0] tick_inc;
    logic [7:0]  chop_inc;
    logic [7:0]  step_inc;
    logic [7:0]  on_lim;
    logic [7:0]  chop_lim;
    logic [7:0]  steps_lim;
    logic [15:0] half_lim;
    logic        cycle_done;
    logic        step_done;

    // Zero counts act as one.
    assign on_lim     = (cfg.on_ticks == 8'd0) ? 8'd1 : cfg.on_ticks;
    assign chop_lim   = (cfg.chop_cycles == 8'd0) ? 8'd1 : cfg.chop_cycles;
    assign steps_lim  = (cfg.steps_per_run == 8'd0) ? 8'd1 : cfg.steps_per_run;
    assign tick_inc   = tick_reg + 16'd1;
    assign chop_inc   = chop_reg + 8'd1;
    assign step_inc   = step_reg + 8'd1;
    assign half_lim   = half_reg ? {8'd0, cfg.off_ticks} : {8'd0, on_lim};
    assign cycle_done = (chop_inc >= chop_lim) || (chop_inc == 8'd0);
    assign step_done  = (step_inc >= steps_lim) || (step_inc == 8'd0);

    // Next state
    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        half_next  = half_reg;
        tick_next  = tick_reg;
        chop_next  = chop_reg;
        step_next  = step_reg;
        led_next   = led_reg;
        unique case (mode_reg)
            MODE_CHOP:
            begin
                tick_next = tick_inc;
                if (tick_inc >= half_lim)
                begin
                    tick_next = 16'd0;
                    if (!half_reg && cfg.off_ticks != 8'd0)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b0;
                        chop_next = chop_inc;
                        if (cycle_done)
                        begin
                            chop_next  = 8'd0;
                            phase_next = phase_reg + 2'd1;
                            if (phase_reg == 2'd3)
                            begin
                                if (cfg.gap_ticks != 16'd0)
                                begin
                                    mode_next = MODE_GAP;
                                end
                                else if (step_done)
                                begin
                                    step_next = 8'd0;
                                    mode_next = MODE_IDLE;
                                end
                                else
                                begin
                                    step_next = step_inc;
                                end
                            end
                        end
                    end
                end
            end
            MODE_GAP:
            begin
                tick_next = tick_inc;
                if (tick_inc >= cfg.gap_ticks || tick_inc == 16'd0)
                begin
                    tick_next = 16'd0;
                    if (step_done)
                    begin
                        step_next = 8'd0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        step_next = step_inc;
                        mode_next = MODE_CHOP;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (button)
                begin
                    led_next   = 1'b0;
                    phase_next = 2'd0;
                    half_next  = 1'b0;
                    tick_next  = 16'd0;
                    chop_next  = 8'd0;
                    step_next  = 8'd0;
                    mode_next  = MODE_CHOP;
                end
                else
                begin
                    led_next = 1'b1;
                end
            end
        endcase
    end

    // Outputs for the tick being taken
    always_comb
    begin
        logic [3:0] pat;
        logic [1:0] order;
        order = cfg.reverse ? ~phase_reg : phase_reg;
        pat   = 4'b0000;
        if (mode_reg == MODE_CHOP && !half_reg)
        begin
            pat = phase_pattern(order);
        end
        res.pin_a1   = pat[3];
        res.pin_a2   = pat[2];
        res.pin_b1   = pat[1];
        res.pin_b2   = pat[0];
        res.led_on   = led_next;
        res.busy_res = (mode_reg == MODE_CHOP) || (mode_reg == MODE_GAP) || button;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            phase_reg <= 2'd0;
            half_reg  <= 1'b0;
            tick_reg  <= 16'd0;
            chop_reg  <= 8'd0;
            step_reg  <= 8'd0;
            led_reg   <= 1'b1;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            half_reg  <= half_next;
            tick_reg  <= tick_next;
            chop_reg  <= chop_next;
            step_reg  <= step_next;
            led_reg   <= led_next;
        end
    end

endmodule
`default_nettype wire
